### sv/svpc_pkg.sv
// shared types, codes and constants for the stepper valve position controller
package svpc_pkg;

    // number of motor phases and coil drive width
    localparam int unsigned PhaseCount = 4;
    localparam int unsigned CoilBits   = 4;

    // transaction opcodes
    typedef enum logic [2:0] {
        OP_MOTOR_TICK = 3'd0,
        OP_SEQ_TICK   = 3'd1,
        OP_START_HOME = 3'd2,
        OP_START_INC  = 3'd3,
        OP_START_DEC  = 3'd4
    } opcode_t;

    // sequencer modes
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_HOME = 2'd1,
        MODE_INC  = 2'd2,
        MODE_DEC  = 2'd3
    } mode_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_HOLD_TICKS    = 2'd0,
        REG_HOMING_TRAVEL = 2'd1,
        REG_HOMING_ADJUST = 2'd2,
        REG_MAX_TARGET    = 2'd3
    } reg_idx_t;

    // configuration register reset values
    localparam logic [7:0]  HOLD_TICKS_RST    = 8'd10;
    localparam logic [15:0] HOMING_TRAVEL_RST = 16'd2000;
    localparam logic [15:0] HOMING_ADJUST_RST = 16'd100;
    localparam logic [15:0] MAX_TARGET_RST    = 16'd2000;

    // configuration as seen by the step logic
    typedef struct packed {
        logic [7:0]  hold_ticks;
        logic [15:0] homing_travel;
        logic [15:0] homing_adjust;
        logic [15:0] max_target;
    } cfg_t;

    // one result transaction
    typedef struct packed {
        logic [CoilBits-1:0] coils;
        logic [15:0]         position;
        logic [15:0]         target_position;
        logic                busy_res;
    } result_t;

    // coil pattern energized for each phase
    function automatic logic [CoilBits-1:0] coil_of_phase(input logic [1:0] phase);
        logic [CoilBits-1:0] pat;
        case (phase)
            2'd0:    pat = 4'hC;
            2'd1:    pat = 4'h6;
            2'd2:    pat = 4'h3;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

### sv/svpc_cfg_regs.sv
// apb configuration registers of the stepper valve position controller
module svpc_cfg_regs
    import svpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign idx   = reg_idx_t'(paddr[3:2]);
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    // register writes on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_ticks    <= HOLD_TICKS_RST;
            cfg_reg.homing_travel <= HOMING_TRAVEL_RST;
            cfg_reg.homing_adjust <= HOMING_ADJUST_RST;
            cfg_reg.max_target    <= MAX_TARGET_RST;
        end else if (wr_en) begin
            case (idx)
                REG_HOLD_TICKS:    cfg_reg.hold_ticks    <= pwdata[7:0];
                REG_HOMING_TRAVEL: cfg_reg.homing_travel <= pwdata[15:0];
                REG_HOMING_ADJUST: cfg_reg.homing_adjust <= pwdata[15:0];
                REG_MAX_TARGET:    cfg_reg.max_target    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back mux
    always_comb begin
        case (idx)
            REG_HOLD_TICKS:    prdata = {24'd0, cfg_reg.hold_ticks};
            REG_HOMING_TRAVEL: prdata = {16'd0, cfg_reg.homing_travel};
            REG_HOMING_ADJUST: prdata = {16'd0, cfg_reg.homing_adjust};
            REG_MAX_TARGET:    prdata = {16'd0, cfg_reg.max_target};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

### sv/svpc_step_core.sv
// controller state registers and the per-transaction update logic
module svpc_step_core
    import svpc_pkg::*;
#(
    parameter int unsigned POS_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic [2:0]  opcode,
    input  logic [15:0] move_steps,
    input  cfg_t        cfg,
    output result_t     result
);

    localparam logic [2:0] STEP_0 = 3'd0;
    localparam logic [2:0] STEP_1 = 3'd1;
    localparam logic [2:0] STEP_2 = 3'd2;
    localparam logic [2:0] STEP_3 = 3'd3;

    logic [POS_BITS-1:0] cur_pos_reg, cur_pos_next;
    logic [POS_BITS-1:0] tgt_pos_reg, tgt_pos_next;
    logic [POS_BITS-1:0] pending_reg, pending_next;
    logic [1:0]          phase_reg, phase_next;
    logic [1:0]          last_phase_reg, last_phase_next;
    logic [7:0]          start_hold_reg, start_hold_next;
    logic [7:0]          stop_hold_reg, stop_hold_next;
    mode_t               mode_reg, mode_next;
    logic [2:0]          step_reg, step_next;
    logic [CoilBits-1:0] coil_reg, coil_next;

    // operands resized to the position width
    logic [POS_BITS-1:0] move;
    logic [POS_BITS-1:0] lim;
    logic [POS_BITS-1:0] travel;
    logic [POS_BITS-1:0] adjust;
    logic [POS_BITS:0]   dec_sum;

    assign move    = POS_BITS'(move_steps);
    assign lim     = POS_BITS'(cfg.max_target);
    assign travel  = POS_BITS'(cfg.homing_travel);
    assign adjust  = POS_BITS'(cfg.homing_adjust);
    assign dec_sum = {1'b0, tgt_pos_reg} + {1'b0, move};

    // next state for one transaction
    always_comb begin
        cur_pos_next    = cur_pos_reg;
        tgt_pos_next    = tgt_pos_reg;
        pending_next    = pending_reg;
        phase_next      = phase_reg;
        last_phase_next = last_phase_reg;
        start_hold_next = start_hold_reg;
        stop_hold_next  = stop_hold_reg;
        mode_next       = mode_reg;
        step_next       = step_reg;
        coil_next       = coil_reg;

        case (opcode_t'(opcode))
            OP_MOTOR_TICK: begin
                if (start_hold_reg != 8'd0) begin
                    start_hold_next = start_hold_reg - 8'd1;
                    coil_next       = coil_of_phase(last_phase_reg);
                end else if (cur_pos_reg == tgt_pos_reg) begin
                    if (stop_hold_reg != 8'd0) begin
                        stop_hold_next = stop_hold_reg - 8'd1;
                        coil_next      = coil_of_phase(phase_reg);
                    end else begin
                        coil_next = '0;
                    end
                end else if (cur_pos_reg < tgt_pos_reg) begin
                    cur_pos_next    = cur_pos_reg + POS_BITS'(1);
                    phase_next      = phase_reg - 2'd1;
                    last_phase_next = phase_reg - 2'd1;
                    coil_next       = coil_of_phase(phase_reg - 2'd1);
                end else begin
                    cur_pos_next    = cur_pos_reg - POS_BITS'(1);
                    phase_next      = phase_reg + 2'd1;
                    last_phase_next = phase_reg + 2'd1;
                    coil_next       = coil_of_phase(phase_reg + 2'd1);
                end
            end
            OP_SEQ_TICK: begin
                case (mode_reg)
                    MODE_HOME: begin
                        case (step_reg)
                            STEP_0: begin
                                cur_pos_next = travel;
                                tgt_pos_next = '0;
                                step_next    = STEP_1;
                            end
                            STEP_1, STEP_3: begin
                                if (tgt_pos_reg == cur_pos_reg) begin
                                    tgt_pos_next = '0;
                                    cur_pos_next = '0;
                                    step_next    = step_reg + 3'd1;
                                end
                            end
                            STEP_2: begin
                                tgt_pos_next = adjust;
                                step_next    = STEP_3;
                            end
                            default: begin
                                mode_next = MODE_IDLE;
                                step_next = STEP_0;
                            end
                        endcase
                    end
                    MODE_INC, MODE_DEC: begin
                        case (step_reg)
                            STEP_0: begin
                                start_hold_next = cfg.hold_ticks;
                                stop_hold_next  = cfg.hold_ticks;
                                if (mode_reg == MODE_INC) begin
                                    tgt_pos_next = (tgt_pos_reg > pending_reg) ?
                                                   tgt_pos_reg - pending_reg : '0;
                                end else begin
                                    tgt_pos_next = tgt_pos_reg + pending_reg;
                                end
                                step_next = STEP_1;
                            end
                            STEP_1: begin
                                if (tgt_pos_reg == cur_pos_reg) begin
                                    step_next    = STEP_2;
                                    pending_next = '0;
                                end
                            end
                            default: begin
                                mode_next = MODE_IDLE;
                                step_next = STEP_0;
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
            OP_START_HOME: begin
                mode_next       = MODE_HOME;
                step_next       = STEP_0;
                pending_next    = '0;
                start_hold_next = cfg.hold_ticks;
                stop_hold_next  = cfg.hold_ticks;
            end
            OP_START_INC: begin
                mode_next       = MODE_INC;
                step_next       = STEP_0;
                start_hold_next = cfg.hold_ticks;
                stop_hold_next  = cfg.hold_ticks;
                pending_next    = (move > tgt_pos_reg) ? tgt_pos_reg : move;
            end
            OP_START_DEC: begin
                mode_next       = MODE_DEC;
                step_next       = STEP_0;
                start_hold_next = cfg.hold_ticks;
                stop_hold_next  = cfg.hold_ticks;
                if (dec_sum >= {1'b0, lim}) begin
                    pending_next = (lim > tgt_pos_reg) ? lim - tgt_pos_reg : '0;
                end else begin
                    pending_next = move;
                end
            end
            default: ;
        endcase
    end

    // state registers, updated once per processed transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_pos_reg    <= '0;
            tgt_pos_reg    <= '0;
            pending_reg    <= '0;
            phase_reg      <= '0;
            last_phase_reg <= '0;
            start_hold_reg <= '0;
            stop_hold_reg  <= '0;
            mode_reg       <= MODE_IDLE;
            step_reg       <= STEP_0;
            coil_reg       <= '0;
        end else if (fire) begin
            cur_pos_reg    <= cur_pos_next;
            tgt_pos_reg    <= tgt_pos_next;
            pending_reg    <= pending_next;
            phase_reg      <= phase_next;
            last_phase_reg <= last_phase_next;
            start_hold_reg <= start_hold_next;
            stop_hold_reg  <= stop_hold_next;
            mode_reg       <= mode_next;
            step_reg       <= step_next;
            coil_reg       <= coil_next;
        end
    end

    // result fields come from the updated state
    assign result.coils           = coil_next;
    assign result.position        = 16'(cur_pos_next);
    assign result.target_position = 16'(tgt_pos_next);
    assign result.busy_res        = (mode_next != MODE_IDLE);

endmodule

### sv/stepper_valve_position_controller_unit.sv
// top level of the stepper valve position controller
//
//  port group   direction  handshake          payload
//  s_*          in         s_valid / s_ready  s_opcode, s_move_steps
//  m_*          out        m_valid / m_ready  m_coils, m_position, m_target_position, m_busy_res
//  apb          in         psel/penable       paddr, pwdata, prdata
//
//  one transaction per cycle sustained while m_ready is high; after acceptance a transaction
//  passes the input register, then the update logic into the result register, and m_valid rises
//  reset is synchronous and active low; it returns state, valid flags and config registers to defaults
//  when m_ready is low the result holds, one more transaction waits in the input
//  register, and s_ready drops only when both are full
module stepper_valve_position_controller_unit
    import svpc_pkg::*;
#(
    parameter int unsigned POS_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_opcode,
    input  logic [15:0]         s_move_steps,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CoilBits-1:0] m_coils,
    output logic [15:0]         m_position,
    output logic [15:0]         m_target_position,
    output logic                m_busy_res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic        in_valid_reg;
    logic [2:0]  opcode_reg;
    logic [15:0] move_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     result;
    cfg_t        cfg;
    logic        fire;

    assign pready  = 1'b1;
    assign fire    = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | fire;

    // configuration registers
    svpc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // state and update logic
    svpc_step_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .opcode     (opcode_reg),
        .move_steps (move_reg),
        .cfg        (cfg),
        .result     (result)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            opcode_reg <= s_opcode;
            move_reg   <= s_move_steps;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_coils           = out_reg.coils;
    assign m_position        = out_reg.position;
    assign m_target_position = out_reg.target_position;
    assign m_busy_res        = out_reg.busy_res;

endmodule
